>>> rtl/core/htfd_pkg.sv
// Shared types, constants and the CRC-8 byte update for the humidity/temperature
// frame decoder. No dependencies.
`default_nettype none

package htfd_pkg;

  localparam int unsigned FRAME_BYTES = 6;

  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
  localparam logic [1:0] STATUS_HUM_CRC  = 2'd2;

  localparam int unsigned TPROD_W = 31;
  localparam int unsigned HPROD_W = 30;

  localparam logic [14:0] TEMP_SCALE = 15'd17500;
  localparam logic [13:0] HUM_SCALE  = 14'd10000;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
  localparam logic [16:0] WORD_DIV = 17'd65535;

  typedef struct packed {
    logic [15:0]        temp_word;
    logic [15:0]        hum_word;
    logic [TPROD_W-1:0] temp_prod;
    logic [HPROD_W-1:0] hum_prod;
    logic [1:0]         status;
  } frame_rec_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/htfd_frame.sv
// Input register, byte position tracking, CRC checks and word assembly.
// Emits one frame record with scaled products per complete frame. Uses htfd_pkg.
`default_nettype none

module htfd_frame (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          data_byte,
  input  wire logic                frame_start,
  output logic                     rec_valid,
  input  wire logic                rec_ready,
  output htfd_pkg::frame_rec_t     rec
);

  logic       s0_valid;
  logic [7:0] s0_byte;
  logic       s0_start;

  logic [2:0]  pos, pos_next;
  logic [7:0]  crc, crc_next;
  logic [15:0] temp_hold, temp_hold_next;
  logic [15:0] hum_hold, hum_hold_next;
  logic        temp_fail, temp_fail_next;

  logic [2:0] pos_eff;
  logic       finish;
  logic       s1_free;
  logic       s0_go;
  htfd_pkg::frame_rec_t rec_next;

  assign pos_eff = (s0_start || (pos >= 3'(htfd_pkg::FRAME_BYTES)))
                   ? htfd_pkg::POS_T_MSB : pos;
  assign finish  = (pos_eff == htfd_pkg::POS_H_CRC);
  assign s1_free = !rec_valid || rec_ready;
  assign s0_go   = s0_valid && (!finish || s1_free);
  assign in_ready = !s0_valid || s0_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_ready) begin
      s0_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s0_byte  <= data_byte;
      s0_start <= frame_start;
    end
  end

  always_comb begin
    crc_next       = crc;
    temp_hold_next = temp_hold;
    hum_hold_next  = hum_hold;
    temp_fail_next = temp_fail;
    pos_next       = (pos_eff == htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_MSB : pos_eff + 3'd1;
    unique case (pos_eff)
      htfd_pkg::POS_T_MSB: begin
        crc_next       = htfd_pkg::crc8_feed(htfd_pkg::CRC_INIT, s0_byte);
        temp_hold_next = {s0_byte, 8'h00};
        temp_fail_next = 1'b0;
      end
      htfd_pkg::POS_T_LSB: begin
        crc_next       = htfd_pkg::crc8_feed(crc, s0_byte);
        temp_hold_next = {temp_hold[15:8], s0_byte};
      end
      htfd_pkg::POS_T_CRC: begin
        temp_fail_next = (crc != s0_byte);
        crc_next       = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_H_MSB: begin
        crc_next      = htfd_pkg::crc8_feed(htfd_pkg::CRC_INIT, s0_byte);
        hum_hold_next = {s0_byte, 8'h00};
      end
      htfd_pkg::POS_H_LSB: begin
        crc_next      = htfd_pkg::crc8_feed(crc, s0_byte);
        hum_hold_next = {hum_hold[15:8], s0_byte};
      end
      default: begin
        crc_next = htfd_pkg::CRC_INIT;
      end
    endcase
  end

  always_comb begin
    rec_next.temp_word = temp_hold;
    rec_next.hum_word  = hum_hold;
    rec_next.temp_prod = htfd_pkg::TPROD_W'(htfd_pkg::TEMP_SCALE)
                       * htfd_pkg::TPROD_W'(temp_hold);
    rec_next.hum_prod  = htfd_pkg::HPROD_W'(htfd_pkg::HUM_SCALE)
                       * htfd_pkg::HPROD_W'(hum_hold);
    priority if (temp_fail) begin
      rec_next.status = htfd_pkg::STATUS_TEMP_CRC;
    end else if (crc != s0_byte) begin
      rec_next.status = htfd_pkg::STATUS_HUM_CRC;
    end else begin
      rec_next.status = htfd_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= htfd_pkg::POS_T_MSB;
      crc       <= htfd_pkg::CRC_INIT;
      temp_hold <= '0;
      hum_hold  <= '0;
      temp_fail <= 1'b0;
    end else if (s0_go) begin
      pos       <= pos_next;
      crc       <= crc_next;
      temp_hold <= temp_hold_next;
      hum_hold  <= hum_hold_next;
      temp_fail <= temp_fail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (s1_free) begin
      rec_valid <= s0_go && finish;
    end
    if (s1_free && s0_go && finish) begin
      rec <= rec_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/htfd_scale.sv
// Result register: divides the scaled products by 65535 and applies the
// temperature offset. Uses htfd_pkg.
`default_nettype none

module htfd_scale (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 rec_valid,
  output logic                      rec_ready,
  input  wire htfd_pkg::frame_rec_t rec,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [15:0]               temp_word,
  output logic [15:0]               hum_word,
  output logic signed [14:0]        temp_centi,
  output logic [13:0]               hum_centi,
  output logic [1:0]                status
);

  // p = 65535*q + r: q0 = p >> 16, r0 = (p & 0xFFFF) + q0, one correction step
  logic [14:0] tq0, tq;
  logic [16:0] tr0;
  logic [13:0] hq0, hq;
  logic [16:0] hr0;
  logic signed [15:0] tc;

  assign tq0 = rec.temp_prod[htfd_pkg::TPROD_W-1:16];
  assign tr0 = {1'b0, rec.temp_prod[15:0]} + 17'(tq0);
  assign tq  = tq0 + 15'(tr0 >= htfd_pkg::WORD_DIV);

  assign hq0 = rec.hum_prod[htfd_pkg::HPROD_W-1:16];
  assign hr0 = {1'b0, rec.hum_prod[15:0]} + 17'(hq0);
  assign hq  = hq0 + 14'(hr0 >= htfd_pkg::WORD_DIV);

  assign tc = $signed({1'b0, tq}) - htfd_pkg::TEMP_OFFSET;

  assign rec_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_ready) begin
      out_valid <= rec_valid;
    end
    if (rec_ready && rec_valid) begin
      temp_word  <= rec.temp_word;
      hum_word   <= rec.hum_word;
      temp_centi <= tc[14:0];
      hum_centi  <= hq;
      status     <= rec.status;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/humidity_temp_frame_decoder_unit.sv
// Top level of the humidity/temperature frame decoder.
// Depends on htfd_pkg, htfd_frame and htfd_scale.
//
//   channel  handshake             payload
//   in       in_valid / in_ready   data_byte, frame_start
//   out      out_valid / out_ready temp_word, hum_word, temp_centi, hum_centi, status
//
// One byte per cycle is accepted while in_ready is high; a result passes through the input
// register, the frame register with products and the result register after its sixth byte.
// Reset clears the valid bits, the byte position, the running CRC and the held words.
// A stalled output holds its result; bytes keep flowing until a finished frame
// needs the frame register while it is still full.
`default_nettype none

module humidity_temp_frame_decoder_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         data_byte,
  input  wire logic               frame_start,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [15:0]             temp_word,
  output logic [15:0]             hum_word,
  output logic signed [14:0]      temp_centi,
  output logic [13:0]             hum_centi,
  output logic [1:0]              status
);

  logic                 rec_valid;
  logic                 rec_ready;
  htfd_pkg::frame_rec_t rec;

  htfd_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .rec_valid   (rec_valid),
    .rec_ready   (rec_ready),
    .rec         (rec)
  );

  htfd_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .temp_word  (temp_word),
    .hum_word   (hum_word),
    .temp_centi (temp_centi),
    .hum_centi  (hum_centi),
    .status     (status)
  );

endmodule

`default_nettype wire

>>> tb/tb_humidity_temp_frame_decoder_unit.sv
// Testbench for humidity_temp_frame_decoder_unit: drives six-byte readout frames
// with CRC-8 checks and compares each decoded reading against an in-bench decoder.
// Depends on htfd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_humidity_temp_frame_decoder_unit;

  typedef struct {
    logic [7:0] value;
    bit         first;
    bit         drain;
    int         gap_cap;
  } rx_byte_t;

  typedef struct {
    logic [15:0]        t_word;
    logic [15:0]        h_word;
    logic signed [14:0] t_centi;
    logic [13:0]        h_centi;
    logic [1:0]         stat;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         data_byte = '0;
  logic               frame_start = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        temp_word;
  logic [15:0]        hum_word;
  logic signed [14:0] temp_centi;
  logic [13:0]        hum_centi;
  logic [1:0]         status;

  rx_byte_t byte_queue[$];
  reading_t readings_due[$];

  // decoder state
  logic [2:0] dec_pos = htfd_pkg::POS_T_MSB;
  logic [7:0] dec_crc = htfd_pkg::CRC_INIT;
  logic [15:0] dec_temp = '0;
  logic [15:0] dec_hum = '0;
  bit         dec_temp_bad = 1'b0;

  int error_count = 0;
  int results_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit byte_taken = 1'b0;

  humidity_temp_frame_decoder_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .temp_word   (temp_word),
    .hum_word    (hum_word),
    .temp_centi  (temp_centi),
    .hum_centi   (hum_centi),
    .status      (status)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ htfd_pkg::CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      3: return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic log_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic decode_byte(input logic [7:0] b, input bit first);
    logic [2:0] p;
    reading_t r;
    p = (first || dec_pos >= htfd_pkg::FRAME_BYTES) ? htfd_pkg::POS_T_MSB : dec_pos;
    case (p)
      htfd_pkg::POS_T_MSB: begin
        dec_crc = crc_step(htfd_pkg::CRC_INIT, b);
        dec_temp = {b, 8'h00};
        dec_temp_bad = 1'b0;
      end
      htfd_pkg::POS_T_LSB: begin
        dec_crc = crc_step(dec_crc, b);
        dec_temp[7:0] = b;
      end
      htfd_pkg::POS_T_CRC: begin
        dec_temp_bad = (dec_crc != b);
        dec_crc = htfd_pkg::CRC_INIT;
      end
      htfd_pkg::POS_H_MSB: begin
        dec_crc = crc_step(htfd_pkg::CRC_INIT, b);
        dec_hum = {b, 8'h00};
      end
      htfd_pkg::POS_H_LSB: begin
        dec_crc = crc_step(dec_crc, b);
        dec_hum[7:0] = b;
      end
      default: begin
        if (dec_temp_bad) begin
          r.stat = htfd_pkg::STATUS_TEMP_CRC;
        end else if (dec_crc != b) begin
          r.stat = htfd_pkg::STATUS_HUM_CRC;
        end else begin
          r.stat = htfd_pkg::STATUS_OK;
        end
        r.t_word = dec_temp;
        r.h_word = dec_hum;
        r.t_centi = 15'(int'(dec_temp) * 17500 / 65535 - 4500);
        r.h_centi = 14'(int'(dec_hum) * 10000 / 65535);
        readings_due.push_back(r);
        dec_crc = htfd_pkg::CRC_INIT;
      end
    endcase
    dec_pos = (p == htfd_pkg::POS_H_CRC) ? htfd_pkg::POS_T_MSB : p + 3'd1;
  endtask

  task automatic queue_byte(input logic [7:0] v, input bit first, input bit drain,
                            input int gap_cap);
    rx_byte_t e;
    e.value = v;
    e.first = first;
    e.drain = drain;
    e.gap_cap = gap_cap;
    byte_queue.push_back(e);
  endtask

  task automatic queue_frame(input logic [15:0] tw, input logic [15:0] hw, input bit t_bad,
                             input bit h_bad, input bit mark, input bit drain,
                             input int gap_cap);
    logic [7:0] tc;
    logic [7:0] hc;
    tc = crc_step(crc_step(htfd_pkg::CRC_INIT, tw[15:8]), tw[7:0]);
    hc = crc_step(crc_step(htfd_pkg::CRC_INIT, hw[15:8]), hw[7:0]);
    if (t_bad) tc ^= 8'($urandom_range(1, 255));
    if (h_bad) hc ^= 8'($urandom_range(1, 255));
    queue_byte(tw[15:8], mark, drain, gap_cap);
    queue_byte(tw[7:0], 1'b0, 1'b0, gap_cap);
    queue_byte(tc, 1'b0, 1'b0, gap_cap);
    queue_byte(hw[15:8], 1'b0, 1'b0, gap_cap);
    queue_byte(hw[7:0], 1'b0, 1'b0, gap_cap);
    queue_byte(hc, 1'b0, 1'b0, gap_cap);
  endtask

  // sender: holds each byte until accepted, optional gap, optional drain
  always @(negedge clk) begin : drive_bytes
    rx_byte_t nxt;
    if (!rst) begin
      if (in_valid && !byte_taken) begin
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (byte_queue.size() != 0 &&
                   !(byte_queue[0].drain && readings_due.size() != 0)) begin
        nxt = byte_queue.pop_front();
        data_byte <= nxt.value;
        frame_start <= nxt.first;
        in_valid <= 1'b1;
        gap_left = $urandom_range(0, nxt.gap_cap);
      end else begin
        in_valid <= 1'b0;
      end
      byte_taken = 1'b0;
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: checks results, then feeds accepted bytes to the decoder
  always @(posedge clk) begin : watch_ports
    reading_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          log_error("result transaction with no reading pending");
        end else begin
          want = readings_due.pop_front();
          if (temp_word !== want.t_word)
            log_error($sformatf("temp_word %h, want %h", temp_word, want.t_word));
          if (hum_word !== want.h_word)
            log_error($sformatf("hum_word %h, want %h", hum_word, want.h_word));
          if (temp_centi !== want.t_centi)
            log_error($sformatf("temp_centi %0d, want %0d", temp_centi, want.t_centi));
          if (hum_centi !== want.h_centi)
            log_error($sformatf("hum_centi %0d, want %0d", hum_centi, want.h_centi));
          if (status !== want.stat)
            log_error($sformatf("status %0d, want %0d", status, want.stat));
        end
        results_seen++;
        stall_left = $urandom_range(0, (results_seen % 160 < 40) ? 0 : 6);
      end
      if (in_valid && in_ready) begin
        decode_byte(data_byte, frame_start);
        byte_taken = 1'b1;
      end
    end
  end

  initial begin : stimulus
    int spins;
    int cap;
    // directed: extremes, both-bad, dropped partial, temp-only and hum-only failures
    queue_frame(16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 0);
    queue_frame(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 0);
    queue_byte(8'hA5, 1'b1, 1'b0, 2);
    queue_byte(8'h5A, 1'b0, 1'b0, 2);
    queue_frame(16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1, 1'b1, 3);
    queue_frame(16'h1234, 16'hFFFE, 1'b0, 1'b1, 1'b1, 1'b0, 6);

    while (byte_queue.size() < 2000) begin
      cap = ((byte_queue.size() / 250) % 3 == 1) ? 0 : 6;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8))
          queue_byte(8'($urandom), ($urandom_range(0, 3) == 0), 1'b0, cap);
      end else begin
        queue_frame(pick_word(), pick_word(), ($urandom_range(0, 5) == 0),
                    ($urandom_range(0, 5) == 0), ($urandom_range(0, 3) != 0),
                    ($urandom_range(0, 99) == 0), cap);
      end
    end

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || in_valid) @(negedge clk);
    spins = 0;
    while (readings_due.size() != 0 && spins < 100000) begin
      @(posedge clk);
      spins++;
    end
    if (readings_due.size() != 0)
      log_error($sformatf("%0d readings never arrived", readings_due.size()));
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> files.f
rtl/core/htfd_pkg.sv
rtl/core/htfd_frame.sv
rtl/core/htfd_scale.sv
rtl/core/humidity_temp_frame_decoder_unit.sv
tb/tb_humidity_temp_frame_decoder_unit.sv
